FILE: rtl/tbc_pkg.sv
// ----------------------------------------------------------------------------
// tbc_pkg
// Shared types, constants and the restoring-division step for the timebase
// time converter.
// ----------------------------------------------------------------------------
package tbc_pkg;

  localparam logic [31:0] NS_PER_SEC      = 32'd1000000000;
  localparam logic [31:0] TPS_RESET       = 32'd24000000;
  localparam logic [12:0] TPU_RESET       = 13'd24;
  localparam int          DIV_STEPS       = 64;

  localparam logic [0:0]  REG_TICKS_PER_SEC  = 1'b0;
  localparam logic [0:0]  REG_TICKS_PER_USEC = 1'b1;

  typedef enum logic [2:0] {
    MODE_TICKS_TO_NS     = 3'd0,
    MODE_TICKS_TO_SEC_US = 3'd1,
    MODE_NS_TO_TICKS     = 3'd2,
    MODE_SEC_NS_TO_TICKS = 3'd3,
    MODE_INTERVAL        = 3'd4
  } mode_t;

  // Side-band data that rides along with a divider beat.
  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] d;
    logic [12:0] ud;
    logic [63:0] acc;
  } side_t;

  typedef struct packed {
    logic [31:0] rem;
    logic [63:0] nq;
  } div_state_t;

  // One quotient bit: the top dividend bit moves into the partial remainder,
  // the new quotient bit moves into the bottom of nq.
  function automatic div_state_t div_step(logic [31:0] rem, logic [63:0] nq,
                                          logic [31:0] den);
    logic [32:0] t;
    logic [32:0] diff;
    div_state_t  r;
    t    = {rem, nq[63]};
    diff = t - {1'b0, den};
    if (t >= {1'b0, den}) begin
      r.rem = diff[31:0];
      r.nq  = {nq[62:0], 1'b1};
    end else begin
      r.rem = t[31:0];
      r.nq  = {nq[62:0], 1'b0};
    end
    return r;
  endfunction

endpackage

FILE: rtl/timebase_time_converter.sv
// ----------------------------------------------------------------------------
// timebase_time_converter
// Converts between timer ticks and nanoseconds, seconds and microseconds, and turns a scaled interval into ticks.
// ----------------------------------------------------------------------------
// Requests enter on the req channel (req_valid / req_stall) with a mode and
// its operands; each request yields exactly one beat on the rsp channel
// (rsp_valid / rsp_stall) carrying whole and fraction.
// The tick rate is written through wr_en / wr_index / wr_data; the user must
// write it only while the block is idle, which the block itself does not enforce; a register holding zero acts as one.
// An accepted request passes through one operand stage, a 64-stage
// divider, a multiply stage, an add stage, a second 64-stage divider
// and the output register before its response. The two dividers compute
// one quotient bit per stage.
// Throughput is one request per cycle while the response beat is not stalled.
// Reset empties the pipeline and loads the rate registers with 24 MHz.
// While the response beat is stalled the whole pipeline holds and
// req_stall is raised; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module timebase_time_converter (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [0:0]  wr_index,
  input  logic [31:0] wr_data,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [2:0]  mode,
  input  logic [63:0] value,
  input  logic [31:0] seconds,
  input  logic [31:0] interval,
  input  logic [31:0] scale,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [63:0] whole,
  output logic [31:0] fraction
);
  import tbc_pkg::*;

  logic [31:0] tps;
  logic [12:0] tpu;
  logic        en;

  always_ff @(posedge clk) begin
    if (rst) begin
      tps <= TPS_RESET;
      tpu <= TPU_RESET;
    end else if (wr_en) begin
      if (wr_index == REG_TICKS_PER_SEC) begin
        tps <= wr_data;
      end else begin
        tpu <= wr_data[12:0];
      end
    end
  end

  assign en        = !(rsp_valid && rsp_stall);
  assign req_stall = !en;

  // Operand stage.
  logic        p_vld;
  logic [2:0]  p_mode;
  logic [63:0] p_value;
  logic [31:0] p_seconds;
  logic [63:0] p_prod;
  logic [31:0] p_d;
  logic [12:0] p_ud;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld <= 1'b0;
    end else if (en) begin
      p_vld <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_mode    <= mode;
      p_value   <= value;
      p_seconds <= seconds;
      p_prod    <= {32'd0, interval} * {32'd0, scale};
      p_d       <= (tps == 32'd0) ? 32'd1 : tps;
      p_ud      <= (tpu == 13'd0) ? 13'd1 : tpu;
    end
  end

  logic [63:0] num1;
  logic [31:0] den1;
  side_t       side1;

  always_comb begin
    num1 = (p_mode == MODE_INTERVAL) ? p_prod : p_value;
    den1 = (p_mode == MODE_TICKS_TO_NS || p_mode == MODE_TICKS_TO_SEC_US) ?
           p_d : NS_PER_SEC;
    side1.mode = p_mode;
    side1.d    = p_d;
    side1.ud   = p_ud;
    side1.acc  = {p_seconds, p_value[31:0]};
  end

  logic        v1;
  logic [63:0] q1;
  logic [31:0] r1;
  side_t       s1;

  tbc_div u_div1 (
    .clk(clk), .rst(rst), .en(en),
    .in_vld(p_vld), .num(num1), .den(den1), .side_in(side1),
    .out_vld(v1), .quo(q1), .rem(r1), .side_out(s1)
  );

  // Multiply stage: whole-second part and remainder scaled by the rate, or by NS_PER_SEC in ticks-to-ns mode.
  logic [63:0] sec_part;
  logic [31:0] rem_part;
  logic [31:0] k;
  logic        m_vld;
  logic [2:0]  m_mode;
  logic [31:0] m_d;
  logic [12:0] m_ud;
  logic [63:0] m_sec;
  logic [31:0] m_rem;
  logic [63:0] m_lo;
  logic [31:0] m_hi;
  logic [63:0] m_r;

  always_comb begin
    if (s1.mode == MODE_SEC_NS_TO_TICKS) begin
      sec_part = {32'd0, s1.acc[63:32]};
      rem_part = s1.acc[31:0];
    end else begin
      sec_part = q1;
      rem_part = r1;
    end
    k = (s1.mode == MODE_TICKS_TO_NS) ? NS_PER_SEC : s1.d;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_vld <= 1'b0;
    end else if (en) begin
      m_vld <= v1;
    end
  end

  // Only the low half of the upper partial product survives the wrap.
  always_ff @(posedge clk) begin
    if (en) begin
      m_mode <= s1.mode;
      m_d    <= s1.d;
      m_ud   <= s1.ud;
      m_sec  <= sec_part;
      m_rem  <= rem_part;
      m_lo   <= {32'd0, sec_part[31:0]} * {32'd0, k};
      m_hi   <= sec_part[63:32] * k;
      m_r    <= {32'd0, rem_part} * {32'd0, k};
    end
  end

  // Add stage: whole-second product modulo 2^64 (the seconds in ticks-to-sec-us mode), second divide operands.
  logic        a_vld;
  logic [63:0] a_num;
  logic [31:0] a_den;
  side_t       a_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (en) begin
      a_vld <= m_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_side.mode <= m_mode;
      a_side.d    <= m_d;
      a_side.ud   <= m_ud;
      if (m_mode == MODE_TICKS_TO_SEC_US) begin
        a_num      <= {32'd0, m_rem};
        a_den      <= {19'd0, m_ud};
        a_side.acc <= m_sec;
      end else begin
        a_num      <= m_r;
        a_den      <= (m_mode == MODE_TICKS_TO_NS) ? m_d : NS_PER_SEC;
        a_side.acc <= m_lo + {m_hi, 32'd0};
      end
    end
  end

  logic        v2;
  logic [63:0] q2;
  logic [31:0] r2_unused;
  side_t       s2;

  tbc_div u_div2 (
    .clk(clk), .rst(rst), .en(en),
    .in_vld(a_vld), .num(a_num), .den(a_den), .side_in(a_side),
    .out_vld(v2), .quo(q2), .rem(r2_unused), .side_out(s2)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (en) begin
      rsp_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      case (s2.mode)
        MODE_TICKS_TO_SEC_US: begin
          whole    <= s2.acc;
          fraction <= q2[31:0];
        end
        MODE_TICKS_TO_NS, MODE_NS_TO_TICKS, MODE_SEC_NS_TO_TICKS,
        MODE_INTERVAL: begin
          whole    <= s2.acc + q2;
          fraction <= 32'd0;
        end
        default: begin
          whole    <= 64'd0;
          fraction <= 32'd0;
        end
      endcase
    end
  end

endmodule

FILE: rtl/tbc_div.sv
// ----------------------------------------------------------------------------
// tbc_div
// Pipelined restoring divider, 64 by 32 bits, one quotient bit per stage.
// ----------------------------------------------------------------------------
module tbc_div (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_vld,
  input  logic [63:0]   num,
  input  logic [31:0]   den,
  input  tbc_pkg::side_t side_in,
  output logic          out_vld,
  output logic [63:0]   quo,
  output logic [31:0]   rem,
  output tbc_pkg::side_t side_out
);
  import tbc_pkg::*;

  logic                vld [DIV_STEPS];
  div_state_t          st  [DIV_STEPS];
  logic [31:0]         dn  [DIV_STEPS];
  side_t               sd  [DIV_STEPS];

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_stage
    logic        vld_prev;
    div_state_t  st_prev;
    logic [31:0] dn_prev;
    side_t       sd_prev;

    if (i == 0) begin : g_first
      assign vld_prev = in_vld;
      assign st_prev  = '{rem: 32'd0, nq: num};
      assign dn_prev  = den;
      assign sd_prev  = side_in;
    end else begin : g_next
      assign vld_prev = vld[i-1];
      assign st_prev  = st[i-1];
      assign dn_prev  = dn[i-1];
      assign sd_prev  = sd[i-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (en) begin
        vld[i] <= vld_prev;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st[i] <= div_step(st_prev.rem, st_prev.nq, dn_prev);
        dn[i] <= dn_prev;
        sd[i] <= sd_prev;
      end
    end
  end

  assign out_vld  = vld[DIV_STEPS-1];
  assign quo      = st[DIV_STEPS-1].nq;
  assign rem      = st[DIV_STEPS-1].rem;
  assign side_out = sd[DIV_STEPS-1];

endmodule
